@@ hw/rtl/east_pkg.sv @@
// Shared types and constants for the encoder angle and speed tracker.
// Holds the command codes, status codes, datapath operations and the
// controller/datapath interface structs. No dependencies.
package east_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // Quotient bits resolved per divider step
   localparam int DIV_DIGIT_W = 4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_XFER    = 2'd1;
   localparam logic [1:0] STATUS_GLITCH  = 2'd2;

   typedef enum logic [2:0] {
      CMD_SAMPLE      = 3'd0,
      CMD_SPEED_TICK  = 3'd1,
      CMD_CLEAR       = 3'd2,
      CMD_CLEAR_SPEED = 3'd3,
      CMD_ALIGN       = 3'd4,
      CMD_SET_OFFSET  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_REVERSE     = 3'd0,
      CSR_POLE_PAIRS  = 3'd1,
      CSR_MAX_DELTA   = 3'd2,
      CSR_MAX_ERRORS  = 3'd3,
      CSR_SPEED_SCALE = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SAMPLE,
      OP_MUL_RAW,
      OP_EL_SPEED,
      OP_EL_ANGLE,
      OP_ALIGN,
      OP_SET_OFFSET,
      OP_CLEAR,
      OP_CLEAR_SPEED,
      OP_TICK_MUL,
      OP_TICK_SAT,
      OP_TICK_SUM,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_DIV_DONE,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic sample_good;
   } dp_status_type;

endpackage

@@ hw/rtl/east_ctrl.sv @@
// Sequencer for the encoder tracker: steps each accepted beat through the
// datapath operations and owns the handshake state. Depends on east_pkg.
module east_ctrl
   import east_pkg::*;
#(
   parameter int DIV_STEPS = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_command,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SAMPLE,
      S_SPD_WAIT,
      S_EL_SPEED,
      S_EL_ANGLE,
      S_ALIGN_MUL,
      S_ALIGN_WAIT,
      S_ALIGN,
      S_SET_OFFSET,
      S_CLEAR,
      S_CLEAR_SPEED,
      S_TICK_MUL,
      S_TICK_SAT,
      S_TICK_SUM,
      S_DIV_START,
      S_DIV_STEP,
      S_DIV_DONE,
      S_PUBLISH
   } state_type;

   state_type        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             publish;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign publish   = (state_ff == S_PUBLISH) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      dp_cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dp_cmd.op = OP_LOAD;
               case (req_command)
                  CMD_SAMPLE:      state_in = S_SAMPLE;
                  CMD_SPEED_TICK:  state_in = S_TICK_MUL;
                  CMD_CLEAR:       state_in = S_CLEAR;
                  CMD_CLEAR_SPEED: state_in = S_CLEAR_SPEED;
                  CMD_ALIGN:       state_in = S_ALIGN_MUL;
                  CMD_SET_OFFSET:  state_in = S_SET_OFFSET;
                  default:         state_in = S_PUBLISH;
               endcase
            end
         end
         S_SAMPLE: begin
            dp_cmd.op = OP_SAMPLE;
            // drop straight to the result on a rejected frame
            state_in  = dp_status.sample_good ? S_SPD_WAIT : S_PUBLISH;
         end
         S_SPD_WAIT: begin
            dp_cmd.op = OP_MUL_RAW;
            state_in  = S_EL_SPEED;
         end
         S_EL_SPEED: begin
            dp_cmd.op = OP_EL_SPEED;
            state_in  = S_EL_ANGLE;
         end
         S_EL_ANGLE: begin
            dp_cmd.op = OP_EL_ANGLE;
            state_in  = S_PUBLISH;
         end
         S_ALIGN_MUL: begin
            dp_cmd.op = OP_MUL_RAW;
            state_in  = S_ALIGN_WAIT;
         end
         S_ALIGN_WAIT: begin
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            dp_cmd.op = OP_ALIGN;
            state_in  = S_PUBLISH;
         end
         S_SET_OFFSET: begin
            dp_cmd.op = OP_SET_OFFSET;
            state_in  = S_PUBLISH;
         end
         S_CLEAR: begin
            dp_cmd.op = OP_CLEAR;
            state_in  = S_PUBLISH;
         end
         S_CLEAR_SPEED: begin
            dp_cmd.op = OP_CLEAR_SPEED;
            state_in  = S_PUBLISH;
         end
         S_TICK_MUL: begin
            dp_cmd.op = OP_TICK_MUL;
            state_in  = S_TICK_SAT;
         end
         S_TICK_SAT: begin
            dp_cmd.op = OP_TICK_SAT;
            state_in  = S_TICK_SUM;
         end
         S_TICK_SUM: begin
            dp_cmd.op = OP_TICK_SUM;
            state_in  = S_DIV_START;
         end
         S_DIV_START: begin
            dp_cmd.op = OP_DIV_START;
            step_in   = '0;
            state_in  = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            dp_cmd.op = OP_DIV_STEP;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            dp_cmd.op = OP_DIV_DONE;
            state_in  = S_PUBLISH;
         end
         S_PUBLISH: begin
            // hold until the output register is free
            if (publish) begin
               dp_cmd.op = OP_PUBLISH;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/east_dp.sv @@
// Datapath of the encoder tracker: configuration registers, position and
// speed state, the two multipliers, the ring filter and the averaging divider.
// Depends on east_pkg; driven by east_ctrl through dp_cmd_type.
module east_dp
   import east_pkg::*;
#(
   parameter int FILTER_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             dp_cmd,
   output dp_status_type          dp_status,
   input  logic [2:0]             req_command,
   input  logic [15:0]            req_frame,
   input  logic                   req_frame_ok,
   input  logic signed [15:0]     req_angle_value,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic [1:0]             rsp_status,
   output logic                   rsp_reliable,
   output logic signed [15:0]     rsp_mech_angle,
   output logic signed [31:0]     rsp_multi_turn,
   output logic signed [15:0]     rsp_el_angle,
   output logic signed [15:0]     rsp_el_speed,
   output logic signed [15:0]     rsp_avg_speed
);

   localparam int IDX_W     = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int FILL_W    = $clog2(FILTER_DEPTH + 1);
   localparam int SUM_W     = 17 + $clog2(FILTER_DEPTH);
   localparam int DIV_STEPS = (SUM_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
   localparam int DIV_W     = DIV_STEPS * DIV_DIGIT_W;
   localparam int SPROD_W   = 53;
   localparam int Q_W       = SPROD_W - 16;

   // configuration
   logic        rev_ff;
   logic [5:0]  pp_ff;
   logic [14:0] max_delta_ff;
   logic [7:0]  max_err_ff;
   logic [19:0] scale_ff;

   // tracker state
   logic                    init_ff, init_in;
   logic [15:0]             last_raw_ff, last_raw_in;
   logic [15:0]             raw_ff, raw_in;
   logic [31:0]             turn_ff, turn_in;
   logic [7:0]              err_run_ff, err_run_in;
   logic                    reliable_ff, reliable_in;
   logic [15:0]             offset_ff, offset_in;
   logic [31:0]             snap_ff, snap_in;
   logic signed [15:0]      ring_ff [FILTER_DEPTH];
   logic signed [15:0]      ring_in [FILTER_DEPTH];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [15:0]             el_angle_ff, el_angle_in;
   logic [15:0]             el_speed_ff, el_speed_in;
   logic [15:0]             avg_ff, avg_in;
   logic [1:0]              status_ff, status_in;

   // working registers
   logic [15:0]               in_frame_ff, in_frame_in;
   logic                      in_ok_ff, in_ok_in;
   logic [15:0]               in_av_ff, in_av_in;
   logic [15:0]               mul_a_ff, mul_a_in;
   logic [15:0]               mul_prod_ff, mul_prod_in;
   logic signed [SPROD_W-1:0] sprod_ff, sprod_in;
   logic signed [15:0]        spd_ff, spd_in;
   logic [DIV_W-1:0]          num_ff, num_in;
   logic [FILL_W-1:0]         rem_ff, rem_in;
   logic                      neg_ff, neg_in;

   // combinational helpers
   logic [15:0]               last_eff;
   logic [15:0]               delta;
   logic signed [16:0]        delta_sx;
   logic [16:0]               delta_mag;
   logic                      glitch;
   logic [31:0]               delta32;
   logic [31:0]               d32;
   logic [7:0]                err_sat;
   logic                      err_trip;
   logic [15:0]               el_raw;
   logic signed [31:0]        diff_s;
   logic signed [20:0]        scale_s;
   logic signed [SPROD_W-1:0] biased;
   logic signed [Q_W-1:0]     quot;
   logic signed [15:0]        spd_sat;
   logic [SUM_W-1:0]          sum_mag;
   logic [FILL_W-1:0]         div_r;
   logic [DIV_W-1:0]          div_n;
   logic [FILL_W:0]           div_t;
   logic [15:0]               avg_mag;
   logic                      clear_all;

   // ---- configuration port ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff       <= 1'b1;
         pp_ff        <= 6'd4;
         max_delta_ff <= 15'd1024;
         max_err_ff   <= 8'd3;
         scale_ff     <= 20'd10000;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REVERSE:     rev_ff       <= csr_write_data[0];
            CSR_POLE_PAIRS:  pp_ff        <= csr_write_data[5:0];
            CSR_MAX_DELTA:   max_delta_ff <= csr_write_data[14:0];
            CSR_MAX_ERRORS:  max_err_ff   <= csr_write_data[7:0];
            CSR_SPEED_SCALE: scale_ff     <= csr_write_data[19:0];
            default: ;
         endcase
      end
   end

   // ---- sample checks ----
   assign last_eff  = init_ff ? last_raw_ff : in_frame_ff;
   assign delta     = in_frame_ff - last_eff;
   assign delta_sx  = $signed({delta[15], delta});
   assign delta_mag = delta[15] ? 17'(-delta_sx) : 17'(delta_sx);
   assign glitch    = delta_mag > {2'b00, max_delta_ff};
   assign dp_status.sample_good = in_ok_ff && !glitch;

   assign delta32  = {{16{delta[15]}}, delta};
   assign d32      = rev_ff ? (32'd0 - delta32) : delta32;
   assign err_sat  = (err_run_ff == 8'hFF) ? 8'hFF : err_run_ff + 8'd1;
   assign err_trip = err_sat >= max_err_ff;

   // ---- small multiplier, free running, registered ----
   // only the low 16 bits of raw * pole pairs are ever used
   assign mul_prod_in = mul_a_ff * {10'd0, pp_ff};
   assign el_raw      = rev_ff ? (16'd0 - mul_prod_ff) : mul_prod_ff;

   // ---- speed tick ----
   assign diff_s  = $signed(turn_ff - snap_ff);
   assign scale_s = $signed({1'b0, scale_ff});
   // bias negative products so the shift truncates toward zero
   assign biased  = sprod_ff + (sprod_ff[SPROD_W-1] ? SPROD_W'(65535) : SPROD_W'(0));
   assign quot    = biased[SPROD_W-1:16];

   always_comb begin
      if (!quot[Q_W-1] && (|quot[Q_W-2:15])) begin
         spd_sat = 16'sh7FFF;
      end else if (quot[Q_W-1] && !(&quot[Q_W-2:15])) begin
         spd_sat = -16'sh8000;
      end else begin
         spd_sat = quot[15:0];
      end
   end

   // ---- averaging divider: magnitude, DIV_DIGIT_W quotient bits per step ----
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      div_r = rem_ff;
      div_n = num_ff;
      div_t = '0;
      for (int i = 0; i < DIV_DIGIT_W; i++) begin
         div_t = {div_r, div_n[DIV_W-1]};
         div_n = {div_n[DIV_W-2:0], 1'b0};
         if (div_t >= {1'b0, fill_ff}) begin
            div_t    = div_t - {1'b0, fill_ff};
            div_n[0] = 1'b1;
         end
         div_r = div_t[FILL_W-1:0];
      end
   end

   assign avg_mag   = num_ff[15:0];
   assign clear_all = (dp_cmd.op == OP_CLEAR) || (dp_cmd.op == OP_CLEAR_SPEED);

   // ---- next state ----
   always_comb begin
      init_in     = init_ff;
      last_raw_in = last_raw_ff;
      raw_in      = raw_ff;
      turn_in     = turn_ff;
      err_run_in  = err_run_ff;
      reliable_in = reliable_ff;
      offset_in   = offset_ff;
      snap_in     = snap_ff;
      ring_in     = ring_ff;
      sum_in      = sum_ff;
      idx_in      = idx_ff;
      fill_in     = fill_ff;
      el_angle_in = el_angle_ff;
      el_speed_in = el_speed_ff;
      avg_in      = avg_ff;
      status_in   = status_ff;
      in_frame_in = in_frame_ff;
      in_ok_in    = in_ok_ff;
      in_av_in    = in_av_ff;
      mul_a_in    = mul_a_ff;
      sprod_in    = sprod_ff;
      spd_in      = spd_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      neg_in      = neg_ff;

      unique case (dp_cmd.op)
         OP_LOAD: begin
            in_frame_in = req_frame;
            in_ok_in    = req_frame_ok;
            in_av_in    = req_angle_value;
            status_in   = STATUS_OK;
         end
         OP_SAMPLE: begin
            if (!in_ok_ff || glitch) begin
               status_in  = in_ok_ff ? STATUS_GLITCH : STATUS_XFER;
               err_run_in = err_sat;
               if (err_trip) begin
                  reliable_in = 1'b0;
               end
            end else begin
               err_run_in  = '0;
               reliable_in = 1'b1;
               init_in     = 1'b1;
               turn_in     = turn_ff + d32;
               last_raw_in = in_frame_ff;
               raw_in      = in_frame_ff;
               mul_a_in    = d32[15:0];
            end
         end
         OP_MUL_RAW: begin
            mul_a_in = raw_ff;
         end
         OP_EL_SPEED: begin
            el_speed_in = mul_prod_ff;
         end
         OP_EL_ANGLE: begin
            el_angle_in = el_raw + offset_ff;
         end
         OP_ALIGN: begin
            offset_in   = in_av_ff - el_raw;
            el_angle_in = in_av_ff;
         end
         OP_SET_OFFSET: begin
            offset_in = in_av_ff;
         end
         OP_CLEAR, OP_CLEAR_SPEED: begin
            if (dp_cmd.op == OP_CLEAR) begin
               turn_in = {16'd0, raw_ff};
               snap_in = {16'd0, raw_ff};
            end else begin
               snap_in = turn_ff;
            end
            for (int i = 0; i < FILTER_DEPTH; i++) begin
               ring_in[i] = '0;
            end
            sum_in      = '0;
            idx_in      = '0;
            fill_in     = '0;
            last_raw_in = raw_ff;
            avg_in      = '0;
            el_speed_in = '0;
         end
         OP_TICK_MUL: begin
            sprod_in = SPROD_W'(diff_s) * SPROD_W'(scale_s);
            snap_in  = turn_ff;
         end
         OP_TICK_SAT: begin
            spd_in = spd_sat;
         end
         OP_TICK_SUM: begin
            sum_in          = sum_ff - SUM_W'(ring_ff[idx_ff]) + SUM_W'(spd_ff);
            ring_in[idx_ff] = spd_ff;
            idx_in          = (idx_ff == IDX_W'(FILTER_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
            if (fill_ff != FILL_W'(FILTER_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         OP_DIV_START: begin
            num_in = DIV_W'(sum_mag);
            rem_in = '0;
            neg_in = sum_ff[SUM_W-1];
         end
         OP_DIV_STEP: begin
            num_in = div_n;
            rem_in = div_r;
         end
         OP_DIV_DONE: begin
            avg_in = neg_ff ? (16'd0 - avg_mag) : avg_mag;
         end
         OP_NONE, OP_PUBLISH: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= 1'b0;
         last_raw_ff <= '0;
         raw_ff      <= '0;
         turn_ff     <= '0;
         err_run_ff  <= '0;
         reliable_ff <= 1'b0;
         offset_ff   <= '0;
         snap_ff     <= '0;
         ring_ff     <= '{default: '0};
         sum_ff      <= '0;
         idx_ff      <= '0;
         fill_ff     <= '0;
         el_angle_ff <= '0;
         el_speed_ff <= '0;
         avg_ff      <= '0;
         status_ff   <= STATUS_OK;
      end else begin
         init_ff     <= init_in;
         last_raw_ff <= last_raw_in;
         raw_ff      <= raw_in;
         turn_ff     <= turn_in;
         err_run_ff  <= err_run_in;
         reliable_ff <= reliable_in;
         offset_ff   <= offset_in;
         snap_ff     <= snap_in;
         ring_ff     <= ring_in;
         sum_ff      <= sum_in;
         idx_ff      <= idx_in;
         fill_ff     <= fill_in;
         el_angle_ff <= el_angle_in;
         el_speed_ff <= el_speed_in;
         avg_ff      <= avg_in;
         status_ff   <= status_in;
      end
   end

   // payload and working registers carry no reset
   always_ff @(posedge clock) begin
      in_frame_ff <= in_frame_in;
      in_ok_ff    <= in_ok_in;
      in_av_ff    <= in_av_in;
      mul_a_ff    <= mul_a_in;
      mul_prod_ff <= mul_prod_in;
      sprod_ff    <= sprod_in;
      spd_ff      <= spd_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      if (dp_cmd.op == OP_PUBLISH) begin
         rsp_status     <= status_ff;
         rsp_reliable   <= reliable_ff;
         rsp_mech_angle <= turn_ff[15:0];
         rsp_multi_turn <= turn_ff;
         rsp_el_angle   <= el_angle_ff;
         rsp_el_speed   <= el_speed_ff;
         rsp_avg_speed  <= avg_ff;
      end
   end

   // the command code itself is decoded by the sequencer
   logic unused_cmd;
   assign unused_cmd = ^req_command & clear_all & 1'b0;

endmodule

@@ hw/rtl/encoder_angle_speed_tracker_core.sv @@
// Encoder angle and speed tracker, top level.
// Instantiates east_ctrl and east_dp; depends on east_pkg.
//
// Usage:
//   req_* carries one command beat (sample, speed tick, clear, clear speed,
//   align, set offset) under valid/ready. Every beat yields exactly one
//   rsp_* beat with status, reliable flag, multi-turn count, electrical
//   angle, electrical speed and averaged speed as they stand after the
//   command. csr_* writes the five configuration registers, one per cycle,
//   while no beat is in flight.
// Sequencing: the speed tick is set by the 32x20 product, the saturate and
//   ring stages and the 4-bit-per-cycle averaging divider; a good sample by
//   the shared 16x6 multiplier used twice. req_ready returns the cycle the
//   result is loaded, so one beat is in work at a time and a new one is
//   taken while the last result waits.
// Reset: synchronous; restores register defaults and clears all tracker
//   state. A stalled receiver holds the result register; the next result
//   waits in the sequencer until the register is free.
module encoder_angle_speed_tracker_core
   import east_pkg::*;
#(
   parameter int FILTER_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_command,
   input  logic [15:0]            req_frame,
   input  logic                   req_frame_ok,
   input  logic signed [15:0]     req_angle_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic                   rsp_reliable,
   output logic signed [15:0]     rsp_mech_angle,
   output logic signed [31:0]     rsp_multi_turn,
   output logic signed [15:0]     rsp_el_angle,
   output logic signed [15:0]     rsp_el_speed,
   output logic signed [15:0]     rsp_avg_speed,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int SUM_W     = 17 + $clog2(FILTER_DEPTH);
   localparam int DIV_STEPS = (SUM_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   east_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   east_dp #(
      .FILTER_DEPTH (FILTER_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_command      (req_command),
      .req_frame        (req_frame),
      .req_frame_ok     (req_frame_ok),
      .req_angle_value  (req_angle_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_reliable     (rsp_reliable),
      .rsp_mech_angle   (rsp_mech_angle),
      .rsp_multi_turn   (rsp_multi_turn),
      .rsp_el_angle     (rsp_el_angle),
      .rsp_el_speed     (rsp_el_speed),
      .rsp_avg_speed    (rsp_avg_speed)
   );

   // one beat in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat was still in work");

   // a fresh result always comes with the sequencer back at rest
   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while the sequencer was busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_XFER ||
                     rsp_status == STATUS_GLITCH))
      else $error("undefined status code on the result beat");

endmodule

@@ tb/sv/encoder_angle_speed_tracker_checker.sv @@
`timescale 1ns / 100ps
// Response checker for encoder_angle_speed_tracker_core: keeps its own copy of
// the tracker state and registers, predicts every rsp beat and compares it.
// Depends on east_pkg.
module encoder_angle_speed_tracker_checker
   import east_pkg::*;
#(
   parameter int FILTER_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [2:0]             req_command,
   input  logic [15:0]            req_frame,
   input  logic                   req_frame_ok,
   input  logic signed [15:0]     req_angle_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [1:0]             rsp_status,
   input  logic                   rsp_reliable,
   input  logic signed [15:0]     rsp_mech_angle,
   input  logic signed [31:0]     rsp_multi_turn,
   input  logic signed [15:0]     rsp_el_angle,
   input  logic signed [15:0]     rsp_el_speed,
   input  logic signed [15:0]     rsp_avg_speed,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     mismatch_count,
   output int                     pending_count,
   output int                     checked_count
);

   typedef struct packed {
      logic [1:0]         status;
      logic               reliable;
      logic signed [15:0] mech_angle;
      logic signed [31:0] multi_turn;
      logic signed [15:0] el_angle;
      logic signed [15:0] el_speed;
      logic signed [15:0] avg_speed;
   } tracker_view_type;

   tracker_view_type expected_views[$];

   // register copies
   logic        cfg_reverse;
   logic [5:0]  cfg_pole_pairs;
   logic [14:0] cfg_max_delta;
   logic [7:0]  cfg_max_errors;
   logic [19:0] cfg_speed_scale;

   // tracker copy
   logic               seen_first;
   logic [15:0]        last_frame;
   logic [15:0]        cur_raw;
   logic [31:0]        turns;
   logic [7:0]         err_run;
   logic               reliable_q;
   logic [15:0]        offset;
   logic [31:0]        tick_base;
   logic signed [15:0] speed_hist [FILTER_DEPTH];
   int                 hist_sum;
   int                 hist_slot;
   int                 hist_count;
   logic [15:0]        el_angle_q;
   logic [15:0]        el_speed_q;
   logic [15:0]        avg_speed_q;

   function automatic logic [31:0] raw_to_electrical(logic [15:0] raw);
      logic [31:0] prod;
      prod = 32'(raw) * 32'(cfg_pole_pairs);
      return cfg_reverse ? -prod : prod;
   endfunction

   function automatic void note_error();
      if (err_run != 8'hFF) begin
         err_run = err_run + 8'd1;
      end
      if (err_run >= cfg_max_errors) begin
         reliable_q = 1'b0;
      end
   endfunction

   function automatic void restart_speed();
      tick_base = turns;
      hist_sum = 0;
      hist_slot = 0;
      hist_count = 0;
      for (int i = 0; i < FILTER_DEPTH; i++) begin
         speed_hist[i] = '0;
      end
      last_frame = cur_raw;
      avg_speed_q = '0;
      el_speed_q = '0;
   endfunction

   function automatic void reset_tracker();
      cfg_reverse = 1'b1;
      cfg_pole_pairs = 6'd4;
      cfg_max_delta = 15'd1024;
      cfg_max_errors = 8'd3;
      cfg_speed_scale = 20'd10000;
      seen_first = 1'b0;
      last_frame = '0;
      cur_raw = '0;
      turns = '0;
      err_run = '0;
      reliable_q = 1'b0;
      offset = '0;
      el_angle_q = '0;
      restart_speed();
   endfunction

   function automatic logic [1:0] take_sample(logic [15:0] frame, logic ok);
      logic signed [15:0] step;
      logic [31:0]        move;
      if (!ok) begin
         note_error();
         return STATUS_XFER;
      end
      if (!seen_first) begin
         cur_raw = frame;
         last_frame = frame;
         seen_first = 1'b1;
      end
      step = frame - last_frame;
      if (int'(step) > int'(cfg_max_delta) || int'(step) < -int'(cfg_max_delta)) begin
         note_error();
         return STATUS_GLITCH;
      end
      err_run = '0;
      reliable_q = 1'b1;
      move = 32'(step);
      if (cfg_reverse) begin
         move = -move;
      end
      turns = turns + move;
      last_frame = frame;
      cur_raw = frame;
      el_speed_q = 16'(move * 32'(cfg_pole_pairs));
      el_angle_q = 16'(raw_to_electrical(frame) + 32'(offset));
      return STATUS_OK;
   endfunction

   function automatic void speed_tick();
      longint prod;
      longint quot;
      int     speed;
      prod = longint'(signed'(turns - tick_base)) * longint'(cfg_speed_scale);
      quot = prod / 65536;
      tick_base = turns;
      if (quot > 32767) begin
         quot = 32767;
      end else if (quot < -32768) begin
         quot = -32768;
      end
      speed = int'(quot);
      if (hist_slot >= FILTER_DEPTH) begin
         hist_slot = 0;
      end
      hist_sum = hist_sum - int'(speed_hist[hist_slot]);
      speed_hist[hist_slot] = 16'(speed);
      hist_sum = hist_sum + speed;
      hist_slot++;
      if (hist_slot >= FILTER_DEPTH) begin
         hist_slot = 0;
      end
      if (hist_count < FILTER_DEPTH) begin
         hist_count++;
      end
      avg_speed_q = 16'(hist_sum / hist_count);
   endfunction

   function automatic tracker_view_type step_tracker(logic [2:0] cmd, logic [15:0] frame,
                                                     logic ok, logic [15:0] value);
      tracker_view_type view;
      view.status = STATUS_OK;
      case (cmd)
         CMD_SAMPLE: view.status = take_sample(frame, ok);
         CMD_SPEED_TICK: speed_tick();
         CMD_CLEAR: begin
            turns = 32'(cur_raw);
            restart_speed();
         end
         CMD_CLEAR_SPEED: restart_speed();
         CMD_ALIGN: begin
            offset = value - 16'(raw_to_electrical(cur_raw));
            el_angle_q = value;
         end
         CMD_SET_OFFSET: offset = value;
         default: ;
      endcase
      view.reliable = reliable_q;
      view.mech_angle = turns[15:0];
      view.multi_turn = turns;
      view.el_angle = el_angle_q;
      view.el_speed = el_speed_q;
      view.avg_speed = avg_speed_q;
      return view;
   endfunction

   always @(posedge clock) begin
      tracker_view_type seen;
      tracker_view_type want;
      if (reset) begin
         reset_tracker();
         expected_views.delete();
         pending_count <= 0;
      end else begin
         // retire the result first so a beat taken this edge cannot match it
         if (rsp_valid && rsp_ready) begin
            seen.status = rsp_status;
            seen.reliable = rsp_reliable;
            seen.mech_angle = rsp_mech_angle;
            seen.multi_turn = rsp_multi_turn;
            seen.el_angle = rsp_el_angle;
            seen.el_speed = rsp_el_speed;
            seen.avg_speed = rsp_avg_speed;
            checked_count <= checked_count + 1;
            if (expected_views.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("[%0t] rsp beat with no command outstanding: status %0d turns %0d",
                           $realtime, seen.status, seen.multi_turn);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_views.pop_front();
               if (seen.status !== want.status || seen.reliable !== want.reliable ||
                   seen.mech_angle !== want.mech_angle ||
                   seen.multi_turn !== want.multi_turn ||
                   seen.el_angle !== want.el_angle || seen.el_speed !== want.el_speed ||
                   seen.avg_speed !== want.avg_speed) begin
                  if (mismatch_count < 10) begin
                     $display("[%0t] rsp mismatch (expected/actual): status %0d/%0d",
                              $realtime, want.status, seen.status,
                              " reliable %0d/%0d mech %0d/%0d turns %0d/%0d",
                              want.reliable, seen.reliable, want.mech_angle,
                              seen.mech_angle, want.multi_turn, seen.multi_turn,
                              " el_angle %0d/%0d el_speed %0d/%0d avg %0d/%0d",
                              want.el_angle, seen.el_angle, want.el_speed,
                              seen.el_speed, want.avg_speed, seen.avg_speed);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REVERSE: cfg_reverse = csr_write_data[0];
               CSR_POLE_PAIRS: cfg_pole_pairs = csr_write_data[5:0];
               CSR_MAX_DELTA: cfg_max_delta = csr_write_data[14:0];
               CSR_MAX_ERRORS: cfg_max_errors = csr_write_data[7:0];
               CSR_SPEED_SCALE: cfg_speed_scale = csr_write_data[19:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_views.push_back(step_tracker(req_command, req_frame, req_frame_ok,
                                                  req_angle_value));
         end
         pending_count <= expected_views.size();
      end
   end

endmodule

@@ tb/sv/encoder_angle_speed_tracker_core_test.sv @@
`timescale 1ns / 100ps
// Stimulus top for encoder_angle_speed_tracker_core: drives command beats and
// register writes, idles both channels and reports the verdict.
// Depends on east_pkg, the core and encoder_angle_speed_tracker_checker.
module encoder_angle_speed_tracker_core_test;
   import east_pkg::*;

   localparam int FILTER_DEPTH  = 2;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BEATS   = 210;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_command = CMD_SAMPLE;
   logic [15:0]            req_frame = '0;
   logic                   req_frame_ok = 1'b0;
   logic signed [15:0]     req_angle_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_status;
   logic                   rsp_reliable;
   logic signed [15:0]     rsp_mech_angle;
   logic signed [31:0]     rsp_multi_turn;
   logic signed [15:0]     rsp_el_angle;
   logic signed [15:0]     rsp_el_speed;
   logic signed [15:0]     rsp_avg_speed;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   int mismatch_count;
   int pending_count;
   int checked_count;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_sent = 0;
   int samples_sent = 0;
   int ticks_sent = 0;
   int settings_used = 1;
   int cycle_count = 0;
   int walk_limit = 1024;
   logic [15:0] walk_frame = '0;

   encoder_angle_speed_tracker_core #(.FILTER_DEPTH(FILTER_DEPTH)) u_top (.*);

   encoder_angle_speed_tracker_checker #(.FILTER_DEPTH(FILTER_DEPTH)) u_checker (.*);

   always #5 clock = ~clock;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_count, pending_count);
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: random stalls, plus two long hold-offs while the sender keeps going
   initial begin : rsp_side
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done < 2 && beats_sent >= (holds_done == 0 ? 150 : 900)) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_beat(logic [2:0] cmd, logic [15:0] frame, logic ok,
                            logic [15:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_frame <= frame;
      req_frame_ok <= ok;
      req_angle_value <= value;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (cmd == CMD_SAMPLE) begin
         samples_sent++;
      end else if (cmd == CMD_SPEED_TICK) begin
         ticks_sent++;
      end
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic apply_settings(logic rev, logic [5:0] pairs, logic [14:0] limit,
                                 logic [7:0] errors, logic [19:0] scale);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_REVERSE;
      csr_write_data <= 20'(rev);
      @(posedge clock);
      csr_index <= CSR_POLE_PAIRS;
      csr_write_data <= 20'(pairs);
      @(posedge clock);
      csr_index <= CSR_MAX_DELTA;
      csr_write_data <= 20'(limit);
      @(posedge clock);
      csr_index <= CSR_MAX_ERRORS;
      csr_write_data <= 20'(errors);
      @(posedge clock);
      csr_index <= CSR_SPEED_SCALE;
      csr_write_data <= scale;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      walk_limit = int'(limit);
      settings_used++;
   endtask

   task automatic random_phase(int count);
      int                 pick;
      int                 step;
      int                 span;
      int                 burst;
      logic [2:0]         cmd;
      logic [15:0]        frame;
      logic               ok;
      logic [15:0]        value;
      logic signed [15:0] move;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         frame = 16'($urandom);
         ok = 1'($urandom);
         value = 16'($urandom);
         burst = 1;
         cmd = CMD_SAMPLE;
         if (pick < 58) begin
            // walk the shaft: mostly legal moves, some right at or past the limit
            span = $urandom_range(0, 1) ? walk_limit : walk_limit / 8;
            case ($urandom_range(0, 9))
               0: step = walk_limit;
               1: step = -walk_limit;
               2: step = walk_limit + 1;
               3: step = -walk_limit - 1;
               default: step = int'($urandom_range(0, 2 * span)) - span;
            endcase
            frame = walk_frame + 16'(step);
            ok = 1'b1;
         end else if (pick < 63) begin
            ok = 1'b0;
            burst = $urandom_range(1, 6);
         end else if (pick < 67) begin
            ok = 1'b1;
         end else if (pick < 81) begin
            cmd = CMD_SPEED_TICK;
         end else if (pick < 84) begin
            cmd = CMD_CLEAR;
         end else if (pick < 88) begin
            cmd = CMD_CLEAR_SPEED;
         end else if (pick < 93) begin
            cmd = CMD_ALIGN;
         end else if (pick < 97) begin
            cmd = CMD_SET_OFFSET;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
         end
         repeat (burst) send_beat(cmd, frame, ok, value);
         if (cmd == CMD_SAMPLE && ok) begin
            move = frame - walk_frame;
            if (int'(move) <= walk_limit && int'(move) >= -walk_limit) begin
               walk_frame = frame;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 65;

      // directed pass at the reset register values
      send_beat(CMD_SPEED_TICK, 16'h0000, 1'b0, 16'h0000);
      send_beat(CMD_SAMPLE, 16'hFFFF, 1'b0, 16'hFFFF);
      send_beat(CMD_SAMPLE, 16'hFFFF, 1'b1, 16'h0000);   // first good frame
      send_beat(CMD_SAMPLE, 16'h0000, 1'b1, 16'h0000);   // wraps forward by one
      send_beat(CMD_SAMPLE, 16'h0400, 1'b1, 16'h7FFF);   // exactly at the limit
      send_beat(CMD_SAMPLE, 16'h0801, 1'b1, 16'h8000);   // one past: glitch
      send_beat(CMD_SAMPLE, 16'h0000, 1'b0, 16'h1234);
      send_beat(CMD_SAMPLE, 16'h0000, 1'b0, 16'h1234);   // third error drops reliable
      send_beat(CMD_SAMPLE, 16'h0000, 1'b1, 16'h0000);
      send_beat(CMD_SAMPLE, 16'h8000, 1'b1, 16'h0000);   // half-turn jump
      send_beat(CMD_SPEED_TICK, 16'hFFFF, 1'b1, 16'hFFFF);
      send_beat(CMD_SPEED_TICK, 16'h0000, 1'b0, 16'h0000);
      send_beat(CMD_SPEED_TICK, 16'h5A5A, 1'b1, 16'hA5A5); // ring wraps
      send_beat(CMD_ALIGN, 16'h0000, 1'b0, 16'h7FFF);
      send_beat(CMD_SAMPLE, 16'hFC00, 1'b1, 16'h0000);
      send_beat(CMD_SET_OFFSET, 16'hFFFF, 1'b1, 16'h8000);
      send_beat(CMD_SAMPLE, 16'hFF00, 1'b1, 16'h0000);
      send_beat(CMD_SPEED_TICK, 16'h0000, 1'b1, 16'h0000);
      send_beat(CMD_CLEAR, 16'hFFFF, 1'b1, 16'hFFFF);
      send_beat(CMD_SPEED_TICK, 16'h0000, 1'b1, 16'h0000);
      send_beat(CMD_CLEAR_SPEED, 16'h0000, 1'b0, 16'h7FFF);
      send_beat(CMD_UNUSED_LO, 16'hFFFF, 1'b1, 16'hFFFF);
      send_beat(CMD_UNUSED_HI, 16'h0000, 1'b0, 16'h8000);
      send_beat(CMD_ALIGN, 16'hFFFF, 1'b1, 16'h8000);
      finish_phase();
      walk_frame = 16'hFF00;   // last accepted frame of the directed pass

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(1'b0, 6'd1, 15'd32767, 8'd1, 20'd1000000);
            1: apply_settings(1'b1, 6'd32, 15'd0, 8'd255, 20'd1);
            2: apply_settings(1'b0, 6'd63, 15'd300, 8'd0, 20'hFFFFF);
            3: apply_settings(1'b1, 6'd0, 15'd2000, 8'd2, 20'd65536);
            4: apply_settings(1'($urandom), 6'($urandom_range(1, 32)),
                              15'($urandom_range(16, 4096)), 8'($urandom_range(1, 8)),
                              20'($urandom_range(1, 1000000)));
            default: apply_settings(1'b1, 6'd7, 15'd1024, 8'd3, 20'd10000);
         endcase
         if (phase < 2) begin
            send_idle_pct = 31;
            recv_idle_pct = 65;
         end else if (phase < 4) begin
            send_idle_pct = 65;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // long error run so the counter hits its ceiling
         if (phase == 1) begin
            repeat (258) send_beat(CMD_SAMPLE, 16'($urandom), 1'b0, 16'($urandom));
         end
         random_phase(PHASE_BEATS);
         finish_phase();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d command beats (%0d samples, %0d speed ticks) over %0d",
               beats_sent, samples_sent, ticks_sent, settings_used,
               " register settings; %0d results compared, %0d mismatched",
               checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
